@@ sv/npc_pkg.sv @@
// Package for the nearest palette colour block: transfer payload types,
// the link carried between chain cells, and fixed widths and codes.
// No dependencies.
package npc_pkg;

	localparam int COMP_W  = 8;
	localparam int ENTRY_W = 6;
	localparam int DIST_W  = 18;
	localparam int SQ_W    = 2 * COMP_W;
	localparam int CHAIN_W = 8;

	localparam logic [DIST_W-1:0] DIST_INIT = '1;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [ENTRY_W-1:0] entry_index;
		logic [COMP_W-1:0]  red;
		logic [COMP_W-1:0]  green;
		logic [COMP_W-1:0]  blue;
	} req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] nearest_index;
		logic [DIST_W-1:0]  nearest_distance;
	} rsp_t;

	typedef struct packed {
		logic               vld;
		req_t               item;
		logic [CHAIN_W-1:0] best_idx;
		logic [DIST_W-1:0]  best_d;
	} link_t;

endpackage

@@ sv/npc_cell.sv @@
// One palette cell of the chain: holds one entry, takes loads addressed to it,
// and folds its distance into the running best of each passing query.
// Depends on npc_pkg.
module npc_cell import npc_pkg::*; #(
	parameter int CELL_IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  link_t link_in,
	output link_t link_out
);

	logic [COMP_W-1:0] red_q, green_q, blue_q;
	link_t             link_s1;
	logic [SQ_W-1:0]   sq_r_s1, sq_g_s1, sq_b_s1;
	logic [COMP_W-1:0] dr, dg, db;
	logic [DIST_W-1:0] sum_d;
	logic              hit;

	assign hit = link_in.vld && (link_in.item.req_type == REQ_LOAD)
		&& ({2'b00, link_in.item.entry_index} == CHAIN_W'(CELL_IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
		end else if (hit) begin
			red_q   <= link_in.item.red;
			green_q <= link_in.item.green;
			blue_q  <= link_in.item.blue;
		end
	end

	always_comb begin
		dr = (link_in.item.red >= red_q) ? link_in.item.red - red_q
			: red_q - link_in.item.red;
		dg = (link_in.item.green >= green_q) ? link_in.item.green - green_q
			: green_q - link_in.item.green;
		db = (link_in.item.blue >= blue_q) ? link_in.item.blue - blue_q
			: blue_q - link_in.item.blue;
	end

	// stage 1: squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_s1 <= '0;
		end else begin
			link_s1 <= link_in;
		end
	end

	always_ff @(posedge clk) begin
		sq_r_s1 <= SQ_W'(dr) * SQ_W'(dr);
		sq_g_s1 <= SQ_W'(dg) * SQ_W'(dg);
		sq_b_s1 <= SQ_W'(db) * SQ_W'(db);
	end

	// stage 2: sum and compare; strict less keeps the lower index on a tie
	assign sum_d = DIST_W'(sq_r_s1) + DIST_W'(sq_g_s1) + DIST_W'(sq_b_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_out <= '0;
		end else begin
			link_out.vld  <= link_s1.vld;
			link_out.item <= link_s1.item;
			if (link_s1.item.req_type == REQ_QUERY && sum_d < link_s1.best_d) begin
				link_out.best_idx <= CHAIN_W'(CELL_IDX);
				link_out.best_d   <= sum_d;
			end else begin
				link_out.best_idx <= link_s1.best_idx;
				link_out.best_d   <= link_s1.best_d;
			end
		end
	end

endmodule

@@ sv/nearest_palette_color_top.sv @@
// Nearest palette colour by squared RGB distance: a chain of NUM_COLORS cells,
// one per palette entry. Depends on npc_pkg and npc_cell.
//
// Every item, load or query, enters the chain and passes every cell, where it
// is registered in link_s1 and then in link_out, so a new item is taken on
// every clock and busy stays low. A query's result is driven on rsp from the
// last cell's link_out, held for the single cycle that done is high; the
// receiver cannot hold it off. Results come out in query order. Loads travel
// the same path and write their cell on the way, so each query sees exactly
// the loads transferred before it. Loads give no result; a load index at or
// beyond NUM_COLORS is dropped. The palette is all black after reset. Ties go
// to the lowest index.
module nearest_palette_color_top import npc_pkg::*; #(
	parameter int NUM_COLORS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	link_t link [NUM_COLORS+1];

	assign busy = 1'b0;

	always_comb begin
		link[0].vld      = start && !busy;
		link[0].item     = req;
		link[0].best_idx = '0;
		link[0].best_d   = DIST_INIT;
	end

	for (genvar k = 0; k < NUM_COLORS; k++) begin : g_cell
		npc_cell #(
			.CELL_IDX(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.link_in (link[k]),
			.link_out(link[k+1])
		);
	end

	assign done = link[NUM_COLORS].vld && (link[NUM_COLORS].item.req_type == REQ_QUERY);
	assign rsp.nearest_index    = link[NUM_COLORS].best_idx[ENTRY_W-1:0];
	assign rsp.nearest_distance = link[NUM_COLORS].best_d;

endmodule
